// ===== design/lone_pkg.sv =====
`timescale 1ns / 1ps

package lone_pkg;

    localparam int MAX_DEPTH  = 4;
    localparam int COORD_BITS = 16;
    localparam int EXT_W      = COORD_BITS - 1;
    localparam int CODE_W     = 3 * MAX_DEPTH + 1;
    localparam int ROW_W      = CODE_W - 3;
    localparam int ROWS       = 1 << ROW_W;
    localparam int DEPTH_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_SPLIT  = 2'd1,
        FN_REMOVE = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SPLIT   = 2'd1,
        ST_DEPTH   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_ROOT_X     = 3'd0,
        CFG_ROOT_Y     = 3'd1,
        CFG_ROOT_Z     = 3'd2,
        CFG_ROOT_SIZE  = 3'd3,
        CFG_ROOT_DEPTH = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_LK,
        S_SP1,
        S_SP2,
        S_RM,
        S_DONE
    } t_state;

    // memory address source
    typedef enum logic [2:0] {
        A_CLR,
        A_ZERO,
        A_IN_ROW,
        A_CODE_ROW,
        A_CODE,
        A_CUR,
        A_CHILD
    } t_addr_sel;

    typedef enum logic [1:0] {
        W_CLR,
        W_ALL,
        W_DROP
    } t_wdata_sel;

    typedef struct packed {
        logic       load_in;
        t_addr_sel  addr_sel;
        logic       we;
        t_wdata_sel wsel;
        logic       clr_step;
        logic       lk_step;
        logic       set_st;
        t_status    st;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic root_bit;
        logic row_bit0;
        logic child_bit;
        logic code_bit;
        logic code_high;
        logic at_max;
        logic rem_zero;
        logic out_free;
    } t_sts;

    function automatic logic [DEPTH_W-1:0] rem_depth(input logic [DEPTH_W-1:0] level,
                                                     input logic [DEPTH_W-1:0] eff);
        return (level < eff) ? DEPTH_W'(eff - level) : '0;
    endfunction

    // true when a split of this code has no depth left (also for malformed codes)
    function automatic logic no_room(input logic [CODE_W-1:0] code,
                                     input logic [DEPTH_W-1:0] eff);
        logic                ok;
        logic [DEPTH_W-1:0]  lvl;
        ok  = 1'b0;
        lvl = '0;
        for (int l = 0; l <= MAX_DEPTH; l++) begin
            if ((code >> (3 * l)) == CODE_W'(1)) begin
                ok  = 1'b1;
                lvl = DEPTH_W'(l);
            end
        end
        return !ok || (rem_depth(lvl, eff) == '0);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_step(
        input logic signed [COORD_BITS-1:0] c,
        input logic        [EXT_W-1:0]      e,
        input logic                         up
    );
        logic signed [COORD_BITS:0] s;
        logic signed [COORD_BITS:0] ev;
        ev = $signed({2'b00, e});
        s  = up ? ($signed({c[COORD_BITS-1], c}) + ev) : ($signed({c[COORD_BITS-1], c}) - ev);
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            return s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return s[COORD_BITS-1:0];
    endfunction

endpackage

// ===== design/lone_ram.sv =====
`timescale 1ns / 1ps

module lone_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lone_dp.sv =====
`timescale 1ns / 1ps

module lone_dp import lone_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [1:0]                   i_func,
    input  logic [CODE_W-1:0]            i_loc_code,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [CODE_W-1:0]            o_node_code,
    output logic signed [COORD_BITS-1:0] o_node_x,
    output logic signed [COORD_BITS-1:0] o_node_y,
    output logic signed [COORD_BITS-1:0] o_node_z,
    output logic [EXT_W-1:0]             o_node_extents,
    output logic [DEPTH_W-1:0]           o_node_depth
);

    // configuration
    logic signed [COORD_BITS-1:0] r_root_x, r_root_y, r_root_z;
    logic [CFG_DATA_W-1:0]        r_root_size;
    logic [DEPTH_W-1:0]           r_root_depth;
    logic [DEPTH_W-1:0]           eff_depth;

    // working registers
    t_func                        r_func;
    t_status                      r_status;
    logic [CODE_W-1:0]            r_code;
    logic [CODE_W-1:0]            r_c;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic [EXT_W-1:0]             r_ext;
    logic [DEPTH_W-1:0]           r_level;
    logic [ROW_W-1:0]             r_clr_addr;

    // output registers
    logic                         r_out_valid;
    logic [1:0]                   r_o_status;
    logic [CODE_W-1:0]            r_o_code;
    logic signed [COORD_BITS-1:0] r_o_x, r_o_y, r_o_z;
    logic [EXT_W-1:0]             r_o_ext;
    logic [DEPTH_W-1:0]           r_o_depth;

    logic [7:0]                   rd_data;
    logic [7:0]                   wdata;
    logic [ROW_W-1:0]             addr;
    logic [2:0]                   idx;
    logic [EXT_W-1:0]             ce;
    logic [CODE_W-1:0]            child;
    logic                         lk_ok;

    assign eff_depth = (r_root_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                            : r_root_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_x     <= '0;
            r_root_y     <= '0;
            r_root_z     <= '0;
            r_root_size  <= CFG_DATA_W'(256);
            r_root_depth <= DEPTH_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROOT_X:     r_root_x     <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_ROOT_Y:     r_root_y     <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_ROOT_Z:     r_root_z     <= $signed(i_cfg_data[COORD_BITS-1:0]);
                CFG_ROOT_SIZE:  r_root_size  <= i_cfg_data;
                CFG_ROOT_DEPTH: r_root_depth <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // child choice from point against current centre
    assign idx   = {r_pz > r_cz, r_py > r_cy, r_px > r_cx};
    assign ce    = r_ext >> 1;
    assign child = {r_c[CODE_W-4:0], idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= t_func'(i_func);
            r_code  <= i_loc_code;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_pz    <= i_pos_z;
            r_c     <= CODE_W'(1);
            r_cx    <= r_root_x;
            r_cy    <= r_root_y;
            r_cz    <= r_root_z;
            r_ext   <= r_root_size[CFG_DATA_W-1:1];
            r_level <= '0;
        end else if (i_cmd.lk_step) begin
            r_c     <= child;
            r_cx    <= sat_step(r_cx, ce, idx[0]);
            r_cy    <= sat_step(r_cy, ce, idx[1]);
            r_cz    <= sat_step(r_cz, ce, idx[2]);
            r_ext   <= ce;
            r_level <= r_level + DEPTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_OK;
        end else if (i_cmd.load_in) begin
            r_status <= ST_OK;
        end else if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
    end

    always_comb begin
        case (i_cmd.addr_sel)
            A_CLR:      addr = r_clr_addr;
            A_ZERO:     addr = '0;
            A_IN_ROW:   addr = i_loc_code[CODE_W-1:3];
            A_CODE_ROW: addr = r_code[CODE_W-1:3];
            A_CODE:     addr = r_code[ROW_W-1:0];
            A_CUR:      addr = r_c[ROW_W-1:0];
            A_CHILD:    addr = child[ROW_W-1:0];
            default:    addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wsel)
            W_CLR:   wdata = (r_clr_addr == '0) ? 8'b0000_0010 : 8'b0000_0000;
            W_ALL:   wdata = 8'hFF;
            W_DROP:  wdata = rd_data & ~(8'b0000_0001 << r_code[2:0]);
            default: wdata = '0;
        endcase
    end

    lone_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_raddr (addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_sts.clr_last  = (r_clr_addr == {ROW_W{1'b1}});
        o_sts.root_bit  = rd_data[1];
        o_sts.row_bit0  = rd_data[0];
        o_sts.child_bit = rd_data[idx];
        o_sts.code_bit  = rd_data[r_code[2:0]];
        o_sts.code_high = (r_code[CODE_W-1:ROW_W] != '0);
        o_sts.at_max    = (r_level == DEPTH_W'(MAX_DEPTH));
        o_sts.rem_zero  = no_room(r_code, eff_depth);
        o_sts.out_free  = !r_out_valid || i_ready;
    end

    assign lk_ok = (r_func == FN_LOOKUP) && (r_status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            case (r_func)
                FN_LOOKUP: r_o_code <= r_c;
                FN_NONE:   r_o_code <= '0;
                default:   r_o_code <= r_code;
            endcase
            r_o_x     <= lk_ok ? r_cx : '0;
            r_o_y     <= lk_ok ? r_cy : '0;
            r_o_z     <= lk_ok ? r_cz : '0;
            r_o_ext   <= lk_ok ? r_ext : '0;
            r_o_depth <= lk_ok ? rem_depth(r_level, eff_depth) : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_o_status;
    assign o_node_code    = r_o_code;
    assign o_node_x       = r_o_x;
    assign o_node_y       = r_o_y;
    assign o_node_z       = r_o_z;
    assign o_node_extents = r_o_ext;
    assign o_node_depth   = r_o_depth;

endmodule

// ===== design/lone_ctrl.sv =====
`timescale 1ns / 1ps

module lone_ctrl import lone_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    output logic       o_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = A_CUR;
        o_cmd.wsel     = W_CLR;
        o_cmd.st       = ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_cmd.addr_sel = A_CLR;
                o_cmd.we       = 1'b1;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    case (t_func'(i_func))
                        FN_LOOKUP: begin
                            o_cmd.addr_sel = A_ZERO;
                            n_state        = S_ROOT;
                        end
                        FN_SPLIT: begin
                            o_cmd.addr_sel = A_IN_ROW;
                            n_state        = S_SP1;
                        end
                        FN_REMOVE: begin
                            o_cmd.addr_sel = A_IN_ROW;
                            n_state        = S_RM;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ROOT: begin
                if (!i_sts.root_bit) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_MISSING;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.addr_sel = A_CUR;
                    n_state        = S_LK;
                end
            end
            S_LK: begin
                if (i_sts.at_max || !i_sts.row_bit0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.lk_step  = 1'b1;
                    o_cmd.addr_sel = A_CHILD;
                    if (!i_sts.child_bit) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_MISSING;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SP1: begin
                if (!i_sts.code_bit) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_MISSING;
                    n_state      = S_DONE;
                end else if (i_sts.code_high) begin
                    // children lie outside the store; such a code is at the bottom level
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_DEPTH;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.addr_sel = A_CODE;
                    n_state        = S_SP2;
                end
            end
            S_SP2: begin
                o_cmd.addr_sel = A_CODE;
                n_state        = S_DONE;
                if (i_sts.row_bit0) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_SPLIT;
                end else if (i_sts.rem_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_DEPTH;
                end else begin
                    o_cmd.we   = 1'b1;
                    o_cmd.wsel = W_ALL;
                end
            end
            S_RM: begin
                o_cmd.addr_sel = A_CODE_ROW;
                n_state        = S_DONE;
                if (!i_sts.code_bit) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_MISSING;
                end else begin
                    o_cmd.we   = 1'b1;
                    o_cmd.wsel = W_DROP;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/linear_octree_node_engine.sv =====
`timescale 1ns / 1ps
// lookup: one store row read per tree level
// split: up to two row reads and one row write; remove: a row read then a row write
// throughput: one item at a time, next item taken the cycle after the result is registered
// reset (synchronous, active low) runs a clearing pass over all 1024 rows of the presence store,
// leaving only the root present; no items are taken during it, config writes still are

module linear_octree_node_engine import lone_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // input item channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_func,
    input  logic [CODE_W-1:0]            i_loc_code,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    // result item channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [CODE_W-1:0]            o_node_code,
    output logic signed [COORD_BITS-1:0] o_node_x,
    output logic signed [COORD_BITS-1:0] o_node_y,
    output logic signed [COORD_BITS-1:0] o_node_z,
    output logic [EXT_W-1:0]             o_node_extents,
    output logic [DEPTH_W-1:0]           o_node_depth
);

    t_cmd cmd;
    t_sts sts;

    // config registers live in the datapath and can always take a write
    assign o_cfg_ready = 1'b1;

    // sequencer: clearing pass, lookup walk, split and remove read/modify/write
    lone_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // presence store (rows of eight sibling bits), geometry walk and result register
    lone_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_loc_code     (i_loc_code),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_node_code    (o_node_code),
        .o_node_x       (o_node_x),
        .o_node_y       (o_node_y),
        .o_node_z       (o_node_z),
        .o_node_extents (o_node_extents),
        .o_node_depth   (o_node_depth)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lone_pkg::*;

    // run size and safety net
    localparam int N_DIRECTED      = 26;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 10;

    // presence store spans every code of CODE_W bits
    localparam int STORE_SIZE = 1 << CODE_W;
    localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN  = -COORD_MAX - 1;

    localparam logic signed [COORD_BITS-1:0] PMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] PMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // one input item, one result item
    typedef struct packed {
        t_func                         func;
        logic [CODE_W-1:0]             code;
        logic signed [COORD_BITS-1:0]  px;
        logic signed [COORD_BITS-1:0]  py;
        logic signed [COORD_BITS-1:0]  pz;
    } node_req_t;

    typedef struct packed {
        t_status                       status;
        logic [CODE_W-1:0]             code;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
        logic [EXT_W-1:0]              ext;
        logic [DEPTH_W-1:0]            depth;
    } node_rsp_t;

    // directed row: item, and a hand-typed result where it is obvious
    typedef struct packed {
        node_req_t req;
        logic      typed;
        node_rsp_t want;
    } dir_row_t;

    localparam node_rsp_t NO_EXP = '0;

    // directed items, run with the reset settings (root at origin, size 256, depth 4)
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // fresh tree: only the root, any point lands on it
        '{'{FN_LOOKUP, 13'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 13'd1, 16'sd0, 16'sd0, 16'sd0, 15'd128, 3'd4}},
        '{'{FN_LOOKUP, 13'd0, PMAX, PMIN, PMAX}, 1'b1,
          '{ST_OK, 13'd1, 16'sd0, 16'sd0, 16'sd0, 15'd128, 3'd4}},
        // split the root, then again (already split)
        '{'{FN_SPLIT, 13'd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 13'd1, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_SPLIT, 13'd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_SPLIT, 13'd1, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        // code zero never exists
        '{'{FN_SPLIT, 13'd0, PMAX, PMAX, PMAX}, 1'b1,
          '{ST_MISSING, 13'd0, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_REMOVE, 13'd0, PMIN, PMIN, PMIN}, 1'b1,
          '{ST_MISSING, 13'd0, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        // one level down, and a point exactly on the centre
        '{'{FN_LOOKUP, 13'd0, 16'sd1, -16'sd1, 16'sd1}, 1'b0, NO_EXP},
        '{'{FN_LOOKUP, 13'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_EXP},
        '{'{FN_SPLIT, 13'd8191, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_MISSING, 13'd8191, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        // grow one branch down to the last level
        '{'{FN_SPLIT, 13'd13, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_EXP},
        '{'{FN_SPLIT, 13'd111, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_EXP},
        '{'{FN_SPLIT, 13'd888, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_EXP},
        '{'{FN_SPLIT, 13'd7107, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_DEPTH, 13'd7107, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_LOOKUP, 13'd0, 16'sd85, -16'sd40, 16'sd75}, 1'b0, NO_EXP},
        '{'{FN_LOOKUP, 13'd0, PMAX, PMAX, PMAX}, 1'b0, NO_EXP},
        // malformed code length
        '{'{FN_SPLIT, 13'd40, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_MISSING, 13'd40, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        // remove first child: the root looks like a leaf again
        '{'{FN_REMOVE, 13'd8, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 13'd8, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_REMOVE, 13'd8, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_MISSING, 13'd8, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_LOOKUP, 13'd0, -16'sd5, -16'sd5, -16'sd5}, 1'b1,
          '{ST_OK, 13'd1, 16'sd0, 16'sd0, 16'sd0, 15'd128, 3'd4}},
        '{'{FN_SPLIT, 13'd8, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_MISSING, 13'd8, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_LOOKUP, 13'd0, PMIN, PMIN, PMIN}, 1'b0, NO_EXP},
        // remove an inner node, its subtree is orphaned
        '{'{FN_REMOVE, 13'd13, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 13'd13, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_LOOKUP, 13'd0, 16'sd85, -16'sd40, 16'sd75}, 1'b0, NO_EXP},
        // unused function code
        '{'{FN_NONE, 13'd8191, PMAX, PMIN, -16'sd1}, 1'b1, NO_EXP},
        // root split again restores the children and the orphans under 13
        '{'{FN_SPLIT, 13'd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 13'd1, 16'sd0, 16'sd0, 16'sd0, 15'd0, 3'd0}},
        '{'{FN_LOOKUP, 13'd0, -16'sd5, -16'sd5, -16'sd5}, 1'b0, NO_EXP}
    };

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // dut ports
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_func;
    logic [CODE_W-1:0]            i_loc_code;
    logic signed [COORD_BITS-1:0] i_pos_x;
    logic signed [COORD_BITS-1:0] i_pos_y;
    logic signed [COORD_BITS-1:0] i_pos_z;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [1:0]                   o_status;
    logic [CODE_W-1:0]            o_node_code;
    logic signed [COORD_BITS-1:0] o_node_x;
    logic signed [COORD_BITS-1:0] o_node_y;
    logic signed [COORD_BITS-1:0] o_node_z;
    logic [EXT_W-1:0]             o_node_extents;
    logic [DEPTH_W-1:0]           o_node_depth;

    linear_octree_node_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_loc_code     (i_loc_code),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_node_code    (o_node_code),
        .o_node_x       (o_node_x),
        .o_node_y       (o_node_y),
        .o_node_z       (o_node_z),
        .o_node_extents (o_node_extents),
        .o_node_depth   (o_node_depth)
    );

    // shadow of the tree and of the root settings
    bit        node_present [STORE_SIZE];
    int        root_x, root_y, root_z;
    int        root_size, root_depth;
    int        deepest_level;

    // results still owed by the dut, oldest first
    node_rsp_t owed_results [$];
    node_rsp_t head;
    logic      bad;

    // run bookkeeping
    int cycle_count;
    int n_errors;
    int n_lookup, n_split, n_remove, n_noop;
    int n_status [4];
    int burst_left;
    bit tx_calm, rx_calm;
    bit rx_open;
    int rx_hold;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic bit has(int code);
        return code >= 0 && code < STORE_SIZE && node_present[code];
    endfunction

    function automatic int clamp_coord(int v);
        return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    endfunction

    // depth left below a node at this level, root depth capped at MAX_DEPTH
    function automatic int depth_left(int lvl);
        int eff;
        eff = (root_depth < MAX_DEPTH) ? root_depth : MAX_DEPTH;
        if (lvl < 0 || lvl >= eff) return 0;
        return eff - lvl;
    endfunction

    // tree level from the code length, -1 when the length is not 3k+1
    function automatic int code_level(int code);
        int len;
        len = 0;
        while (code != 0) begin
            len++;
            code = code >> 1;
        end
        if (len == 0 || (len - 1) % 3 != 0) return -1;
        return (len - 1) / 3;
    endfunction

    // apply one item to the shadow tree and return the result it must give
    function automatic node_rsp_t octree_step(node_req_t r);
        node_rsp_t rsp;
        int        c, lvl, idx, ce, ext;
        int        cx, cy, cz, px, py, pz;
        bit        ok;
        rsp = '0;
        px  = r.px;
        py  = r.py;
        pz  = r.pz;
        case (r.func)
            FN_LOOKUP: begin
                c   = 1;
                lvl = 0;
                ok  = has(1);
                if (ok) begin
                    cx  = clamp_coord(root_x);
                    cy  = clamp_coord(root_y);
                    cz  = clamp_coord(root_z);
                    ext = root_size >> 1;
                    // descend while the first child exists
                    while (lvl < MAX_DEPTH && has(c << 3)) begin
                        idx = (px > cx ? 1 : 0) + (py > cy ? 2 : 0) + (pz > cz ? 4 : 0);
                        ce  = ext >> 1;
                        cx  = clamp_coord(cx + (((idx & 1) != 0) ? ce : -ce));
                        cy  = clamp_coord(cy + (((idx & 2) != 0) ? ce : -ce));
                        cz  = clamp_coord(cz + (((idx & 4) != 0) ? ce : -ce));
                        ext = ce;
                        c   = (c << 3) | idx;
                        lvl++;
                        if (!has(c)) begin
                            ok = 1'b0;
                            break;
                        end
                    end
                end
                rsp.code = CODE_W'(c);
                if (ok) begin
                    rsp.x     = COORD_BITS'(cx);
                    rsp.y     = COORD_BITS'(cy);
                    rsp.z     = COORD_BITS'(cz);
                    rsp.ext   = EXT_W'(ext);
                    rsp.depth = DEPTH_W'(depth_left(lvl));
                    if (lvl > deepest_level) deepest_level = lvl;
                end else begin
                    rsp.status = ST_MISSING;
                end
            end
            FN_SPLIT: begin
                c        = r.code;
                rsp.code = r.code;
                if (!has(c)) rsp.status = ST_MISSING;
                else if (has(c << 3)) rsp.status = ST_SPLIT;
                else if (depth_left(code_level(c)) == 0) rsp.status = ST_DEPTH;
                else begin
                    for (int i = 0; i < 8; i++)
                        node_present[((c << 3) | i) & (STORE_SIZE - 1)] = 1'b1;
                end
            end
            FN_REMOVE: begin
                c        = r.code;
                rsp.code = r.code;
                if (!has(c)) rsp.status = ST_MISSING;
                else node_present[c] = 1'b0;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // random walk from the root to an existing node, sometimes one step into a hole
    function automatic int pick_node();
        int c;
        c = 1;
        for (int l = 0; l < MAX_DEPTH; l++) begin
            if (!has(c << 3) || $urandom_range(0, 4) == 0) break;
            c = (c << 3) | $urandom_range(0, 7);
            if (!has(c)) break;
        end
        return c;
    endfunction

    // point coordinate: full range, inside the root cube, on sub-centres, or near the centre
    function automatic logic signed [COORD_BITS-1:0] pick_coord(int centre, int ext);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $signed(COORD_BITS'($urandom));
            1:       v = centre + int'($urandom_range(0, 2 * ext)) - ext;
            2:       v = centre + (int'($urandom_range(0, 6)) - 3) * (ext >> $urandom_range(0, 4));
            default: v = centre + int'($urandom_range(0, 8)) - 4;
        endcase
        return COORD_BITS'(clamp_coord(v));
    endfunction

    // one register write, valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROOT_X:     root_x     = $signed(data);
            CFG_ROOT_Y:     root_y     = $signed(data);
            CFG_ROOT_Z:     root_z     = $signed(data);
            CFG_ROOT_SIZE:  root_size  = data;
            CFG_ROOT_DEPTH: root_depth = data[2:0];
            default: ;
        endcase
    endtask

    // offer one item, with a gap at the start of each burst, and log what it owes
    task automatic send_item(input node_req_t r, input logic typed, input node_rsp_t want);
        node_rsp_t rsp;
        int        gap;
        gap = 0;
        if (!tx_calm) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= r.func;
        i_loc_code <= r.code;
        i_pos_x    <= r.px;
        i_pos_y    <= r.py;
        i_pos_z    <= r.pz;
        do @(posedge i_clk); while (!o_ready);
        // item taken at this edge
        rsp = octree_step(r);
        owed_results.push_back(typed ? want : rsp);
        case (r.func)
            FN_LOOKUP: n_lookup++;
            FN_SPLIT:  n_split++;
            FN_REMOVE: n_remove++;
            default:   n_noop++;
        endcase
    endtask

    // result side stalls in alternating open and closed runs of random length
    always @(posedge i_clk) begin
        if (rx_calm) begin
            rx_hold = 0;
            i_ready <= 1'b1;
        end else if (rx_hold == 0) begin
            rx_open = !rx_open;
            rx_hold = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 10);
            i_ready <= rx_open;
        end else begin
            rx_hold--;
        end
    end

    // compare every accepted result against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_status[o_status]++;
            if (owed_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb_top: cycle %0d: result with none owed, status %0d code %0d",
                             cycle_count, o_status, o_node_code);
            end else begin
                head = owed_results.pop_front();
                bad  = (o_status !== head.status) || (o_node_code !== head.code)
                    || (o_node_x !== head.x) || (o_node_y !== head.y)
                    || (o_node_z !== head.z) || (o_node_extents !== head.ext)
                    || (o_node_depth !== head.depth);
                if (bad) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $write("tb_top: cycle %0d: mismatch, expected st %0d code %0d",
                               cycle_count, head.status, head.code);
                        $display(" c (%0d,%0d,%0d) e %0d d %0d",
                                 head.x, head.y, head.z, head.ext, head.depth);
                        $display("tb_top:   actual st %0d code %0d c (%0d,%0d,%0d) e %0d d %0d",
                                 o_status, o_node_code, o_node_x, o_node_y, o_node_z,
                                 o_node_extents, o_node_depth);
                    end
                end
            end
        end
    end

    // hard stop if the run hangs
    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb_top: timeout after %0d cycles, %0d results owed", cycle_count,
                 owed_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        node_req_t                 r;
        int                        sel, code;
        logic [CFG_DATA_W-1:0]     rx, ry, rz, rs;
        logic [2:0]                rd;

        // everything known from time zero
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_func      <= FN_LOOKUP;
        i_loc_code  <= '0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        cycle_count = 0;
        n_errors    = 0;
        burst_left  = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        rx_open     = 1'b0;
        rx_hold     = 0;

        // shadow state after reset: only the root exists
        foreach (node_present[i]) node_present[i] = 1'b0;
        node_present[1] = 1'b1;
        root_x = 0;
        root_y = 0;
        root_z = 0;
        root_size  = 256;
        root_depth = 4;
        deepest_level = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset settings, items wait out the clearing pass
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

        for (int ph = 1; ph <= N_PHASES; ph++) begin
            // settle before touching the registers
            i_valid <= 1'b0;
            while (owed_results.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);

            case (ph)
                // edge of the coordinate space (z at zero), largest cube, depth above the cap
                1: begin
                    rx = PMAX; ry = PMIN; rz = '0; rs = '1; rd = 3'd7;
                end
                // opposite corner, empty cube, no depth at all
                2: begin
                    rx = PMIN; ry = PMAX; rz = PMIN; rs = '0; rd = 3'd0;
                end
                // tiny cube at the origin
                3: begin
                    rx = '0; ry = '0; rz = '0; rs = 16'd1; rd = 3'd4;
                end
                default: begin
                    rx = CFG_DATA_W'($urandom);
                    ry = CFG_DATA_W'($urandom);
                    rz = CFG_DATA_W'($urandom);
                    rs = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(8, 1024));
                    rd = 3'($urandom_range(0, 7));
                end
            endcase
            write_reg(CFG_ROOT_X, rx);
            write_reg(CFG_ROOT_Y, ry);
            write_reg(CFG_ROOT_Z, rz);
            write_reg(CFG_ROOT_SIZE, rs);
            // upper data bits are don't-care for the depth register
            write_reg(CFG_ROOT_DEPTH, {13'($urandom), rd});
            // an index past the last register changes nothing
            write_reg(CFG_IDX_W'(CFG_ROOT_DEPTH) + CFG_IDX_W'($urandom_range(1, 3)),
                      CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;

            // one phase without any idling on either side
            tx_calm = (ph == 3);
            rx_calm = (ph == 3);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                sel  = $urandom_range(0, 99);
                // unused fields carry noise
                r.func = FN_LOOKUP;
                r.code = CODE_W'($urandom);
                r.px   = COORD_BITS'($urandom);
                r.py   = COORD_BITS'($urandom);
                r.pz   = COORD_BITS'($urandom);
                if (sel < 40) begin
                    r.px = pick_coord(root_x, root_size >> 1);
                    r.py = pick_coord(root_y, root_size >> 1);
                    r.pz = pick_coord(root_z, root_size >> 1);
                end else if (sel < 68) begin
                    r.func = FN_SPLIT;
                    r.code = CODE_W'(pick_node());
                end else if (sel < 85) begin
                    // the root stays until the very end
                    code = pick_node();
                    if (code == 1) code = 8 | int'($urandom_range(0, 7));
                    r.func = FN_REMOVE;
                    r.code = CODE_W'(code);
                end else if (sel < 95) begin
                    code = int'($urandom_range(0, STORE_SIZE - 1));
                    if (sel < 90) begin
                        r.func = FN_SPLIT;
                    end else begin
                        r.func = FN_REMOVE;
                        if (code == 1) code = 0;
                    end
                    r.code = CODE_W'(code);
                end else begin
                    r.func = FN_NONE;
                end
                send_item(r, 1'b0, NO_EXP);
            end
        end

        // closing items: drop the root, then nothing can be found or split
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        r = '{FN_REMOVE, 13'd1, 16'sd0, 16'sd0, 16'sd0};
        send_item(r, 1'b0, NO_EXP);
        r = '{FN_LOOKUP, 13'd0, PMIN, PMAX, 16'sd0};
        send_item(r, 1'b0, NO_EXP);
        r = '{FN_SPLIT, 13'd1, 16'sd0, 16'sd0, 16'sd0};
        send_item(r, 1'b0, NO_EXP);
        r = '{FN_REMOVE, 13'd1, 16'sd0, 16'sd0, 16'sd0};
        send_item(r, 1'b0, NO_EXP);
        i_valid <= 1'b0;

        // drain, then wait quietly to catch stray results
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $write("tb_top: %0d items over %0d root settings: ",
               n_lookup + n_split + n_remove + n_noop, N_PHASES + 1);
        $display("%0d lookups, %0d splits, %0d removes, %0d no-ops",
                 n_lookup, n_split, n_remove, n_noop);
        $write("tb_top: ok %0d, already split %0d, depth zero %0d, missing %0d; ",
               n_status[ST_OK], n_status[ST_SPLIT], n_status[ST_DEPTH], n_status[ST_MISSING]);
        $display("deepest walk %0d, %0d mismatches", deepest_level, n_errors);
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/lone_pkg.sv
design/lone_ram.sv
design/lone_dp.sv
design/lone_ctrl.sv
design/linear_octree_node_engine.sv
dv/tb_top.sv
